>>> design/tpmt_pkg.sv
// ----------------------------------------------------------------------------
// tpmt_pkg
// Shared codes and types for the ternary priority match table.
// ----------------------------------------------------------------------------
package tpmt_pkg;

  // Operation codes carried on the input tuser
  localparam logic [1:0] ACT_SEARCH = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  // Verdict of the entry compare unit
  typedef struct packed {
    logic hit;     // entry valid and key matches under its mask
    logic better;  // hit and beats the current best
  } cmp_t;

endpackage

>>> design/tpmt_match.sv
// ----------------------------------------------------------------------------
// tpmt_match
// Entry compare unit: ternary key match of one entry and priority compare
// against the running best of a search.
// ----------------------------------------------------------------------------
module tpmt_match #(
  parameter int KEY_BITS  = 32,
  parameter int PRIO_BITS = 8
) (
  input  logic                 ent_valid,
  input  logic [KEY_BITS-1:0]  ent_key,
  input  logic [KEY_BITS-1:0]  ent_mask,
  input  logic [PRIO_BITS-1:0] ent_prio,
  input  logic [KEY_BITS-1:0]  key,
  input  logic                 found,
  input  logic [PRIO_BITS-1:0] best_prio,
  output tpmt_pkg::cmp_t       res
);

  logic key_eq;

  // masked search key against the stored key
  assign key_eq = ((key & ent_mask) == ent_key);

  // strictly larger priority wins, so ties keep the lower slot
  always_comb begin
    res.hit    = ent_valid && key_eq;
    res.better = res.hit && (!found || (ent_prio > best_prio));
  end

endmodule

>>> design/ternary_priority_match_table_core.sv
// ----------------------------------------------------------------------------
// ternary_priority_match_table_core
// Ternary match table with priority resolution. Insert, delete and search
// words enter on the slave stream; one result word leaves per input word.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Content
// s_*       in         tvalid/tready      tuser: action; tdata: key, mask,
//                                         slot, entry_priority, entry_data
// m_*       out        tvalid/tready      tdata: hit, hit_slot, hit_data,
//                                         hit_priority, status
//
// A search reads the entry memory one slot per cycle through a single read
// port and one compare unit, then loads the result word and returns to idle
// for the next word. Insert writes an in-range slot at accept and then loads
// its result. Delete reads the slot at accept, checks it and writes back a
// cleared entry. After reset a clearing pass writes every slot, during which
// s_tready stays low. One word is in work at a time; the result register lets
// the next word be accepted while a result waits on m_tready.
// ----------------------------------------------------------------------------
module ternary_priority_match_table_core #(
  parameter int ENTRIES   = 64,
  parameter int KEY_BITS  = 32,
  parameter int PRIO_BITS = 8,
  parameter int DATA_BITS = 16,
  // word widths
  localparam int SLOT_BITS = $clog2(ENTRIES),
  localparam int IN_BITS   = 2 * KEY_BITS + SLOT_BITS + PRIO_BITS + DATA_BITS,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 2 + SLOT_BITS + DATA_BITS + PRIO_BITS,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic clk,
  input  logic rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [1:0]           s_tuser,  // action
  input  logic [IN_W-1:0]      s_tdata,  // key, mask, slot, entry_priority, entry_data
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata   // hit, hit_slot, hit_data, hit_priority, status
);

  // input word layout
  localparam int KEY_LO   = 0;
  localparam int MASK_LO  = KEY_BITS;
  localparam int SLOT_LO  = 2 * KEY_BITS;
  localparam int PRIO_LO  = SLOT_LO + SLOT_BITS;
  localparam int DATA_LO  = PRIO_LO + PRIO_BITS;

  // memory entry layout
  localparam int E_KEY   = 0;
  localparam int E_MASK  = KEY_BITS;
  localparam int E_PRIO  = 2 * KEY_BITS;
  localparam int E_DATA  = E_PRIO + PRIO_BITS;
  localparam int E_VALID = E_DATA + DATA_BITS;
  localparam int ENT_W   = E_VALID + 1;

  localparam logic [SLOT_BITS:0]   ENTRIES_V = (SLOT_BITS + 1)'(ENTRIES);
  localparam logic [SLOT_BITS-1:0] LAST_ADDR = SLOT_BITS'(ENTRIES - 1);
  localparam logic [SLOT_BITS-1:0] ADDR_ONE  = SLOT_BITS'(1);

  // sequencer states
  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_DEL_CHK = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0]           state;
  logic [SLOT_BITS-1:0] scan_addr;
  logic                 issue_done;
  logic                 pend;
  logic [SLOT_BITS-1:0] cmp_idx;
  logic                 found;
  logic [SLOT_BITS-1:0] best_slot;
  logic [PRIO_BITS-1:0] best_prio;
  logic [DATA_BITS-1:0] best_data;
  logic                 status_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [KEY_BITS-1:0]  mask_q;
  logic [SLOT_BITS-1:0] slot_q;

  logic [ENT_W-1:0]     mem [ENTRIES];
  logic [ENT_W-1:0]     rd_q;
  logic                 we;
  logic [SLOT_BITS-1:0] wr_addr;
  logic [ENT_W-1:0]     wr_data;
  logic                 rd_en;
  logic [SLOT_BITS-1:0] rd_addr;

  logic [KEY_BITS-1:0]  in_key;
  logic [KEY_BITS-1:0]  in_mask;
  logic [SLOT_BITS-1:0] in_slot;
  logic [PRIO_BITS-1:0] in_prio;
  logic [DATA_BITS-1:0] in_data;
  logic                 in_range;
  logic                 accept;
  logic                 issue;
  logic                 del_ok;
  logic                 out_free;
  tpmt_pkg::cmp_t       cmp;

  // input field unpacking
  assign in_key   = s_tdata[KEY_LO  +: KEY_BITS];
  assign in_mask  = s_tdata[MASK_LO +: KEY_BITS];
  assign in_slot  = s_tdata[SLOT_LO +: SLOT_BITS];
  assign in_prio  = s_tdata[PRIO_LO +: PRIO_BITS];
  assign in_data  = s_tdata[DATA_LO +: DATA_BITS];
  assign in_range = ({1'b0, in_slot} < ENTRIES_V);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign issue    = (state == ST_SCAN) && !issue_done;
  assign out_free = !m_tvalid || m_tready;

  // delete goes through only for a valid slot with an equal stored mask
  assign del_ok = rd_q[E_VALID] && (rd_q[E_MASK +: KEY_BITS] == mask_q);

  // shared compare unit, fed from the registered read data
  tpmt_match #(
    .KEY_BITS  (KEY_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_match (
    .ent_valid (rd_q[E_VALID]),
    .ent_key   (rd_q[E_KEY +: KEY_BITS]),
    .ent_mask  (rd_q[E_MASK +: KEY_BITS]),
    .ent_prio  (rd_q[E_PRIO +: PRIO_BITS]),
    .key       (key_q),
    .found     (found),
    .best_prio (best_prio),
    .res       (cmp)
  );

  // write port select
  always_comb begin
    we      = 1'b0;
    wr_addr = scan_addr;
    wr_data = '0;
    priority if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (accept && (s_tuser == tpmt_pkg::ACT_INSERT) && in_range) begin
      we      = 1'b1;
      wr_addr = in_slot;
      wr_data = {1'b1, in_data, in_prio, in_mask, in_key};
    end else if ((state == ST_DEL_CHK) && del_ok) begin
      we      = 1'b1;
      wr_addr = slot_q;
    end
  end

  // read port select
  always_comb begin
    rd_en   = issue;
    rd_addr = scan_addr;
    if (accept && (s_tuser == tpmt_pkg::ACT_DELETE)) begin
      rd_en   = 1'b1;
      rd_addr = in_slot;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      scan_addr  <= '0;
      issue_done <= 1'b0;
      pend       <= 1'b0;
      found      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // result valid: set on load, cleared once taken
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          scan_addr <= scan_addr + ADDR_ONE;
          if (scan_addr == LAST_ADDR) begin
            scan_addr <= '0;
            state     <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            key_q      <= in_key;
            mask_q     <= in_mask;
            slot_q     <= in_slot;
            found      <= 1'b0;
            status_q   <= 1'b0;
            scan_addr  <= '0;
            issue_done <= 1'b0;
            pend       <= 1'b0;
            unique case (s_tuser)
              tpmt_pkg::ACT_SEARCH: state <= ST_SCAN;
              tpmt_pkg::ACT_DELETE: begin
                if (in_range) begin
                  state <= ST_DEL_CHK;
                end else begin
                  status_q <= 1'b1;
                  state    <= ST_DONE;
                end
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_SCAN: begin
          // one read issued per cycle, compared in the cycle after
          if (issue) begin
            scan_addr <= scan_addr + ADDR_ONE;
            if (scan_addr == LAST_ADDR) begin
              issue_done <= 1'b1;
            end
          end
          pend    <= issue;
          cmp_idx <= scan_addr;
          if (pend && cmp.better) begin
            found     <= 1'b1;
            best_slot <= cmp_idx;
            best_prio <= rd_q[E_PRIO +: PRIO_BITS];
            best_data <= rd_q[E_DATA +: DATA_BITS];
          end
          if (issue_done && !pend) begin
            state <= ST_DONE;
          end
        end
        ST_DEL_CHK: begin
          status_q <= !del_ok;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          // load the result register once it is free
          if (out_free) begin
            m_tdata  <= OUT_W'({status_q,
                                found ? best_prio : {PRIO_BITS{1'b0}},
                                found ? best_data : {DATA_BITS{1'b0}},
                                found ? best_slot : {SLOT_BITS{1'b0}},
                                found});
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
